>>> sv/line_queue_buffer_unit_macros.svh
// Assertion macros used by the line queue buffer RTL.
// Defining ASSERT_OFF removes every check.
`ifndef LINE_QUEUE_BUFFER_UNIT_MACROS_SVH
`define LINE_QUEUE_BUFFER_UNIT_MACROS_SVH

`ifndef ASSERT_OFF
// Check that is suspended while reset is applied.
`define LQB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// Check that must also hold while reset is applied.
`define LQB_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);
`else
`define LQB_ASSERT(lbl, prop, msg)
`define LQB_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

>>> sv/lqb_pkg.sv
package lqb_pkg;

  localparam int unsigned LINE_COUNT_W = 4;

  typedef enum logic [1:0] {
    OP_PUSH    = 2'd0,
    OP_COMMIT  = 2'd1,
    OP_READ    = 2'd2,
    OP_RELEASE = 2'd3
  } op_e;

  // Outcome of one operation, known in the cycle it is accepted.
  typedef struct packed {
    logic                    is_read;
    logic                    status;
    logic                    is_empty;
    logic                    is_full;
    logic [LINE_COUNT_W-1:0] line_count;
  } resp_t;

endpackage

>>> sv/lqb_ram.sv
module lqb_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 512
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> sv/lqb_ctrl.sv
module lqb_ctrl #(
  parameter int unsigned LINES      = 8,
  parameter int unsigned LINE_BYTES = 64,
  localparam int unsigned ADDR_W    = $clog2(LINES * LINE_BYTES)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                accept_i,
  input  logic [1:0]          opcode_i,
  input  logic [7:0]          data_byte_i,
  input  logic [5:0]          read_index_i,
  output logic                ram_we_o,
  output logic [ADDR_W-1:0]   ram_waddr_o,
  output logic [7:0]          ram_wdata_o,
  output logic                ram_re_o,
  output logic [ADDR_W-1:0]   ram_raddr_o,
  output lqb_pkg::resp_t      resp_o
);

  import lqb_pkg::*;

  localparam int unsigned SLOT_W = (LINES > 1) ? $clog2(LINES) : 1;
  localparam int unsigned CNT_W  = $clog2(LINES + 1);
  localparam int unsigned POS_W  = $clog2(LINE_BYTES + 1);

  logic [SLOT_W-1:0] front_q, front_d;
  logic [SLOT_W-1:0] rear_q, rear_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic [POS_W-1:0]  wpos_q, wpos_d;
  logic              full, empty, pos_ok, ridx_ok;
  logic              status;
  logic              push_ok;
  logic [SLOT_W-1:0] front_next, rear_next;
  op_e               op;

  assign op         = op_e'(opcode_i);
  assign full       = count_q == CNT_W'(LINES);
  assign empty      = count_q == '0;
  assign pos_ok     = wpos_q != POS_W'(LINE_BYTES);
  assign ridx_ok    = 32'(read_index_i) < 32'(LINE_BYTES);
  assign front_next = (front_q == SLOT_W'(LINES - 1)) ? '0 : front_q + 1'b1;
  assign rear_next  = (rear_q == SLOT_W'(LINES - 1)) ? '0 : rear_q + 1'b1;

  always_comb begin
    front_d = front_q;
    rear_d  = rear_q;
    count_d = count_q;
    wpos_d  = wpos_q;
    status  = 1'b0;
    push_ok = 1'b0;
    unique case (op)
      OP_PUSH: begin
        if (full || !pos_ok) begin
          status = 1'b1;
        end else begin
          push_ok = 1'b1;
          wpos_d  = wpos_q + 1'b1;
        end
      end
      OP_COMMIT: begin
        if (full) begin
          status = 1'b1;
        end else begin
          rear_d  = rear_next;
          count_d = count_q + 1'b1;
          wpos_d  = '0;
        end
      end
      OP_READ: begin
        status = empty || !ridx_ok;
      end
      OP_RELEASE: begin
        if (empty) begin
          status = 1'b1;
        end else begin
          front_d = front_next;
          count_d = count_q - 1'b1;
        end
      end
      default: begin
        status = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_q <= '0;
      rear_q  <= '0;
      count_q <= '0;
      wpos_q  <= '0;
    end else if (accept_i) begin
      front_q <= front_d;
      rear_q  <= rear_d;
      count_q <= count_d;
      wpos_q  <= wpos_d;
    end
  end

  // Line slot times line length is a multiply by a constant.
  assign ram_we_o    = accept_i && push_ok;
  assign ram_waddr_o = ADDR_W'(ADDR_W'(rear_q) * ADDR_W'(LINE_BYTES)) + ADDR_W'(wpos_q);
  assign ram_wdata_o = data_byte_i;
  assign ram_re_o    = accept_i && (op == OP_READ);
  assign ram_raddr_o = ADDR_W'(ADDR_W'(front_q) * ADDR_W'(LINE_BYTES))
                     + ADDR_W'(read_index_i);

  assign resp_o.is_read    = op == OP_READ;
  assign resp_o.status     = status;
  assign resp_o.is_empty   = count_d == '0;
  assign resp_o.is_full    = count_d == CNT_W'(LINES);
  assign resp_o.line_count = LINE_COUNT_W'(count_d);

endmodule

>>> sv/line_queue_buffer_unit.sv
// Each result is registered in the pending stage, then in the output register.
// Throughput: one item per cycle unless the output is held; a good push writes one byte, each read reads one.
// Reset: rst_ni clears the queue pointers, the line count and both result stages.
// The line memory is not cleared; a byte never written reads back as anything.
`include "line_queue_buffer_unit_macros.svh"

module line_queue_buffer_unit #(
  parameter int unsigned LINES      = 8,
  parameter int unsigned LINE_BYTES = 64
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [1:0] opcode_i,
  input  logic [7:0] data_byte_i,
  input  logic [5:0] read_index_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] read_byte_o,
  output logic       is_empty_o,
  output logic       is_full_o,
  output logic [3:0] line_count_o,
  output logic       status_o
);

  import lqb_pkg::*;

  localparam int unsigned ADDR_W = $clog2(LINES * LINE_BYTES);

  // The controller settles pointers and flags in the cycle an item is
  // accepted and issues at most one memory access. The outcome waits in the
  // pending stage, alongside the registered read data, and is then moved
  // into the output register, which holds it until taken.
  logic              accept;
  logic              ram_we, ram_re;
  logic [ADDR_W-1:0] ram_waddr, ram_raddr;
  logic [7:0]        ram_wdata, ram_rdata;
  resp_t             resp;

  logic  pend_valid_q, pend_valid_d;
  resp_t pend_q;
  logic  pend_move;

  logic       out_valid_q, out_valid_d;
  logic [7:0] out_byte_q;
  resp_t      out_q;

  // The pending stage moves on whenever the output register is free or is
  // being emptied. The memory's read data only changes on a new read, so it
  // stays put while the pending stage is held.
  assign pend_move  = pend_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !pend_valid_q || pend_move;
  assign accept     = in_valid_i && in_ready_o;

  lqb_ctrl #(
    .LINES      (LINES),
    .LINE_BYTES (LINE_BYTES)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .opcode_i     (opcode_i),
    .data_byte_i  (data_byte_i),
    .read_index_i (read_index_i),
    .ram_we_o     (ram_we),
    .ram_waddr_o  (ram_waddr),
    .ram_wdata_o  (ram_wdata),
    .ram_re_o     (ram_re),
    .ram_raddr_o  (ram_raddr),
    .resp_o       (resp)
  );

  lqb_ram #(
    .WIDTH (8),
    .DEPTH (LINES * LINE_BYTES)
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    pend_valid_d = pend_valid_q;
    if (accept) begin
      pend_valid_d = 1'b1;
    end else if (pend_move) begin
      pend_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (pend_move) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      pend_valid_q <= pend_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // Payload stages carry no reset; their valid bits guard them.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      pend_q <= resp;
    end
    if (pend_move) begin
      out_q      <= pend_q;
      // Only a successful read returns a byte; everything else answers zero.
      out_byte_q <= (pend_q.is_read && !pend_q.status) ? ram_rdata : 8'h00;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign read_byte_o  = out_byte_q;
  assign is_empty_o   = out_q.is_empty;
  assign is_full_o    = out_q.is_full;
  assign line_count_o = out_q.line_count;
  assign status_o     = out_q.status;

  // The reset check looks at the cycle after reset, since the output flag may
  // still be unknown at the very first edge, before reset has taken hold.
  `LQB_ASSERT(a_full_count, out_valid_o && is_full_o |-> line_count_o == 4'(LINES), "full without a full count")
  `LQB_ASSERT(a_byte_only_on_done, out_valid_o && read_byte_o != 8'h00 |-> !status_o, "byte returned on a rejected item")
  `LQB_ASSERT(a_stall_means_pending, !in_ready_o |-> pend_valid_q && out_valid_q, "input stalled with room to spare")
  `LQB_ASSERT_ALWAYS(a_reset_clears_out, !rst_ni |=> !out_valid_o, "result shown after reset")

endmodule

>>> test/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import lqb_pkg::*;

  localparam int unsigned LINES        = 8;
  localparam int unsigned LINE_BYTES   = 64;
  localparam int unsigned SLOT_W       = $clog2(LINES);
  localparam int unsigned RANDOM_ITEMS = 1000;
  localparam int unsigned PHASES       = 3;
  localparam int unsigned MOOD_SPAN    = 40;
  // Cycles without any handshake on either channel before the run is abandoned.
  // The longest honest gap is the receiver hold-off plus a few random idles.
  localparam int unsigned STALL_LIMIT  = 2000;
  localparam int unsigned HOLD_CYCLES  = 300;
  // A result passes only the pending stage and the output register, so a handful
  // of spare cycles at the end is enough to catch a stray extra result.
  localparam int unsigned TAIL_CYCLES  = 10;

  // One result item as the block reports it.
  typedef struct packed {
    logic [7:0]              read_byte;
    logic                    is_empty;
    logic                    is_full;
    logic [LINE_COUNT_W-1:0] line_count;
    logic                    status;
  } line_result_t;

  // Biases for the random operation mix, so that the queue is driven to full,
  // drained to empty and has lines pushed past their end.
  typedef enum logic [1:0] {
    MOOD_FILL,
    MOOD_DRAIN,
    MOOD_LONG,
    MOOD_MIXED
  } mood_e;

  // The scoreboard keeps its own copy of the queue and works out, for every
  // accepted item, the one result that the block must give back.
  class line_queue_scoreboard;
    logic [7:0]              line_mem [LINES*LINE_BYTES];
    bit                      written  [LINES*LINE_BYTES];
    logic [SLOT_W-1:0]       front_slot;
    logic [SLOT_W-1:0]       rear_slot;
    logic [LINE_COUNT_W-1:0] held_lines;
    logic [6:0]              write_pos;
    line_result_t            due_q[$];
    int unsigned             errors;
    int unsigned             checked;

    function new();
      front_slot = '0;
      rear_slot  = '0;
      held_lines = '0;
      write_pos  = '0;
      errors     = 0;
      checked    = 0;
      foreach (written[k]) begin
        written[k]  = 1'b0;
        line_mem[k] = 8'h00;
      end
    endfunction

    function int unsigned pending();
      return due_q.size();
    endfunction

    function bit front_byte_written(int unsigned idx);
      return written[front_slot*LINE_BYTES + idx];
    endfunction

    function void note_item(op_e op, logic [7:0] data, logic [5:0] idx);
      line_result_t r;
      bit           full;
      bit           empty;
      full  = held_lines >= LINES;
      empty = held_lines == 0;
      r     = '0;
      case (op)
        OP_PUSH: begin
          if (full || write_pos >= LINE_BYTES) begin
            r.status = 1'b1;
          end else begin
            line_mem[rear_slot*LINE_BYTES + write_pos] = data;
            written[rear_slot*LINE_BYTES + write_pos]  = 1'b1;
            write_pos++;
          end
        end
        OP_COMMIT: begin
          if (full) begin
            r.status = 1'b1;
          end else begin
            rear_slot  = SLOT_W'((32'(rear_slot) + 1) % LINES);
            held_lines = held_lines + 1'b1;
            write_pos  = '0;
          end
        end
        OP_READ: begin
          if (empty || idx >= LINE_BYTES) begin
            r.status = 1'b1;
          end else begin
            r.read_byte = line_mem[front_slot*LINE_BYTES + idx];
          end
        end
        default: begin
          if (empty) begin
            r.status = 1'b1;
          end else begin
            front_slot = SLOT_W'((32'(front_slot) + 1) % LINES);
            held_lines = held_lines - 1'b1;
          end
        end
      endcase
      r.is_empty   = held_lines == 0;
      r.is_full    = held_lines >= LINES;
      r.line_count = held_lines;
      due_q.push_back(r);
    endfunction

    task report(string msg);
      errors++;
      $display("[%0t] MISMATCH: %s", $time, msg);
    endtask

    task check_result(line_result_t got);
      line_result_t want;
      checked++;
      if (due_q.size() == 0) begin
        report($sformatf("result %0d arrived with nothing outstanding", checked));
      end else begin
        want = due_q.pop_front();
        if (got.read_byte !== want.read_byte)
          report($sformatf("result %0d read_byte %h, expected %h",
                           checked, got.read_byte, want.read_byte));
        if (got.is_empty !== want.is_empty)
          report($sformatf("result %0d is_empty %b, expected %b",
                           checked, got.is_empty, want.is_empty));
        if (got.is_full !== want.is_full)
          report($sformatf("result %0d is_full %b, expected %b",
                           checked, got.is_full, want.is_full));
        if (got.line_count !== want.line_count)
          report($sformatf("result %0d line_count %0d, expected %0d",
                           checked, got.line_count, want.line_count));
        if (got.status !== want.status)
          report($sformatf("result %0d status %b, expected %b",
                           checked, got.status, want.status));
      end
    endtask
  endclass

  // Every input of the block starts at a known value.
  logic       clk_i        = 1'b0;
  logic       rst_ni       = 1'b0;
  logic       in_valid_i   = 1'b0;
  logic [1:0] opcode_i     = OP_PUSH;
  logic [7:0] data_byte_i  = 8'h00;
  logic [5:0] read_index_i = 6'd0;
  logic       out_ready_i  = 1'b0;
  logic       in_ready_o;
  logic       out_valid_o;
  logic [7:0] read_byte_o;
  logic       is_empty_o;
  logic       is_full_o;
  logic [3:0] line_count_o;
  logic       status_o;

  line_queue_scoreboard sb;

  // Idle percentages for each side; the stimulus process changes them per phase.
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;

  // Request for one long receiver hold-off, and the receiver's own count of it.
  logic        hold_wanted = 1'b0;
  bit          hold_taken  = 1'b0;
  int unsigned hold_left   = 0;
  int unsigned quiet_cycles = 0;

  line_queue_buffer_unit #(
    .LINES      (LINES),
    .LINE_BYTES (LINE_BYTES)
  ) uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .opcode_i     (opcode_i),
    .data_byte_i  (data_byte_i),
    .read_index_i (read_index_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .read_byte_o  (read_byte_o),
    .is_empty_o   (is_empty_o),
    .is_full_o    (is_full_o),
    .line_count_o (line_count_o),
    .status_o     (status_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 0;
  end

  // The receiver decides its ready at each falling edge. When a hold-off is
  // requested it keeps ready low for a fixed stretch, counted here, so that
  // the result stages fill and the block has to stall its input.
  always @(negedge clk_i) begin
    if (hold_wanted && !hold_taken) begin
      hold_taken = 1'b1;
      hold_left  = HOLD_CYCLES;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Both channels are sampled at the rising edge, before the block's own
  // registers move. An accepted item is handed to the scoreboard, which
  // queues the result it predicts; an accepted result is checked against
  // the oldest prediction. The same block watches for a hung handshake.
  always @(posedge clk_i) begin
    line_result_t got;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o)
        sb.note_item(op_e'(opcode_i), data_byte_i, read_index_i);
      if (out_valid_o && out_ready_i) begin
        got.read_byte  = read_byte_o;
        got.is_empty   = is_empty_o;
        got.is_full    = is_full_o;
        got.line_count = line_count_o;
        got.status     = status_o;
        sb.check_result(got);
      end
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
          $display("CHECKS FAILED");
          $finish;
        end
      end
    end
  end

  // Offers one item to the block, starting and ending at a falling edge.
  // The line memory is not cleared at reset, so a read of the front line is
  // steered onto a byte that has been written; if that line holds no written
  // byte at all, the item becomes a release instead. Reads while the queue is
  // empty are left alone, since the block must reject them without looking.
  task automatic offer(input op_e op, input logic [7:0] data, input logic [5:0] idx);
    int unsigned known[$];
    if (op == OP_READ && sb.held_lines != 0 && !sb.front_byte_written(idx)) begin
      for (int unsigned k = 0; k < LINE_BYTES; k++)
        if (sb.front_byte_written(k)) known.push_back(k);
      if (known.size() == 0) op = OP_RELEASE;
      else idx = 6'(known[$urandom_range(known.size() - 1)]);
    end
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i   <= 1'b1;
    opcode_i     <= op;
    data_byte_i  <= data;
    read_index_i <= idx;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  function automatic op_e pick_op(mood_e mood);
    int unsigned r;
    r = $urandom_range(99);
    case (mood)
      MOOD_FILL:
        return r < 65 ? OP_PUSH : r < 90 ? OP_COMMIT : r < 96 ? OP_READ : OP_RELEASE;
      MOOD_DRAIN:
        return r < 15 ? OP_PUSH : r < 20 ? OP_COMMIT : r < 60 ? OP_READ : OP_RELEASE;
      MOOD_LONG:
        return r < 96 ? OP_PUSH : r < 98 ? OP_COMMIT : r < 99 ? OP_READ : OP_RELEASE;
      default:
        return op_e'(r % 4);
    endcase
  endfunction

  initial begin
    mood_e mood;
    sb = new();
    mood = MOOD_MIXED;
    send_idle_pct = 23;
    recv_idle_pct = 84;
    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed opening: rejections on an empty queue, the extreme byte values,
    // a commit of a line into which nothing was pushed, and a return to empty.
    offer(OP_READ,    8'h00, 6'd0);
    offer(OP_RELEASE, 8'hFF, 6'd63);
    offer(OP_PUSH,    8'h00, 6'd63);
    offer(OP_PUSH,    8'hFF, 6'd0);
    offer(OP_PUSH,    8'h5A, 6'd0);
    offer(OP_COMMIT,  8'h00, 6'd0);
    offer(OP_READ,    8'h00, 6'd0);
    offer(OP_READ,    8'hFF, 6'd1);
    offer(OP_READ,    8'h00, 6'd2);
    offer(OP_COMMIT,  8'hFF, 6'd63);
    offer(OP_READ,    8'h00, 6'd1);
    offer(OP_RELEASE, 8'h00, 6'd0);
    offer(OP_RELEASE, 8'h00, 6'd0);
    offer(OP_RELEASE, 8'h00, 6'd0);
    offer(OP_READ,    8'hFF, 6'd63);
    offer(OP_PUSH,    8'hA5, 6'd0);
    offer(OP_COMMIT,  8'h00, 6'd0);
    offer(OP_READ,    8'h00, 6'd0);
    offer(OP_RELEASE, 8'h00, 6'd0);

    // Random part in three phases: a slow receiver, then a slow sender, then
    // both flat out, the last one opening with a long receiver hold-off.
    for (int unsigned phase = 0; phase < PHASES; phase++) begin
      if (phase == 1) begin
        send_idle_pct = 84;
        recv_idle_pct = 23;
      end else if (phase == 2) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_wanted  <= 1'b1;
      end
      for (int unsigned n = 0; n < RANDOM_ITEMS / PHASES; n++) begin
        if (n % MOOD_SPAN == 0) mood = mood_e'($urandom_range(3));
        offer(pick_op(mood), 8'($urandom_range(255)), 6'($urandom_range(63)));
      end
    end
    in_valid_i <= 1'b0;

    // Let every outstanding result come back, then give the block a few more
    // cycles in which any surplus result would be caught.
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
